// ----- hw/rtl/pphm_pkg.sv -----
// shared types, constants and register codes of the pulse and hrv monitor
package pphm_pkg;

	// default sizes
	localparam int SMOOTH_TAPS_DEF = 15;
	localparam int BEAT_WINDOW_DEF = 20;

	// field widths
	localparam int SAMPLE_W   = 12;
	localparam int TIME_W     = 32;
	localparam int TOTAL_W    = 16;
	localparam int LEVEL_W    = 12;
	localparam int MS_W       = 16;
	localparam int TOL_W      = 10;
	localparam int HR_W       = 8;
	localparam int RR_W       = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READY_LEVEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REJECT_GAP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE      = 3'd4;

	// register reset values
	localparam logic [LEVEL_W-1:0] PEAK_THRESHOLD_RST = 12'd500;
	localparam logic [LEVEL_W-1:0] READY_LEVEL_RST    = 12'd300;
	localparam logic [MS_W-1:0]    REFRACTORY_RST     = 16'd400;
	localparam logic [MS_W-1:0]    REJECT_GAP_RST     = 16'd2000;
	localparam logic [TOL_W-1:0]   TOLERANCE_RST      = 10'd50;

	// window arithmetic
	localparam int DIV_NUM_W    = 42;
	localparam int DIV_DEN_W    = 32;
	localparam int HR_SCALE     = 60000;
	localparam int RR_DEN_SCALE = 1000;
	localparam int RR_SHIFT     = 10;
	localparam int HR_MAX       = 255;
	localparam int RR_MAX       = 2047;

	// front to back queue
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [LEVEL_W-1:0] peak_threshold;
		logic [LEVEL_W-1:0] ready_level;
		logic [MS_W-1:0]    refractory_ms;
		logic [MS_W-1:0]    reject_gap_ms;
		logic [TOL_W-1:0]   tolerance_ms;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] smoothed;
		logic                sensor_ready;
		logic                peak_found;
		logic [TIME_W-1:0]   beat_time;
	} front_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] smoothed;
		logic                sensor_ready;
		logic                peak_found;
		logic                window_done;
		logic                window_error;
		logic                fatigue;
		logic [HR_W-1:0]     heart_rate_bpm;
		logic [RR_W-1:0]     mean_rr_q10;
	} result_t;

endpackage

// ----- hw/rtl/ppg_pulse_hrv_monitor.sv -----
// An ordinary beat passes the averaging register, the queue and the result register;
// a beat that closes a window is also held for the window pass and two divisions.
// Throughput: one beat per cycle while no window is evaluated and results are popped;
// the window pass over the beat memory and the serial divider hold the input meanwhile.
// Reset: arst_n clears the averaging ring, the control state and the queues and loads
// the register defaults; the beat time memory is not cleared.
module ppg_pulse_hrv_monitor #(
	parameter int SMOOTH_TAPS = pphm_pkg::SMOOTH_TAPS_DEF,
	parameter int BEAT_WINDOW = pphm_pkg::BEAT_WINDOW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [pphm_pkg::SAMPLE_W-1:0]    sample,
	input  logic [pphm_pkg::TIME_W-1:0]      sample_time_ms,
	output logic                             empty,
	input  logic                             pop,
	output logic [pphm_pkg::SAMPLE_W-1:0]    smoothed,
	output logic                             sensor_ready,
	output logic                             peak_found,
	output logic                             window_done,
	output logic                             window_error,
	output logic                             fatigue,
	output logic [pphm_pkg::HR_W-1:0]        heart_rate_bpm,
	output logic [pphm_pkg::RR_W-1:0]        mean_rr_q10,
	input  logic                             cfg_we,
	input  logic [pphm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pphm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pphm_pkg::*;

	cfg_t        cfg_q;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	front_item_t q_wr_item;
	front_item_t q_rd_item;
	result_t     res;
	logic        res_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_threshold <= PEAK_THRESHOLD_RST;
			cfg_q.ready_level    <= READY_LEVEL_RST;
			cfg_q.refractory_ms  <= REFRACTORY_RST;
			cfg_q.reject_gap_ms  <= REJECT_GAP_RST;
			cfg_q.tolerance_ms   <= TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PEAK_THRESHOLD: cfg_q.peak_threshold <= cfg_data[LEVEL_W-1:0];
				REG_READY_LEVEL:    cfg_q.ready_level    <= cfg_data[LEVEL_W-1:0];
				REG_REFRACTORY:     cfg_q.refractory_ms  <= cfg_data[MS_W-1:0];
				REG_REJECT_GAP:     cfg_q.reject_gap_ms  <= cfg_data[MS_W-1:0];
				REG_TOLERANCE:      cfg_q.tolerance_ms   <= cfg_data[TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pphm_front #(
		.SMOOTH_TAPS (SMOOTH_TAPS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.push           (push),
		.full           (full),
		.sample         (sample),
		.sample_time_ms (sample_time_ms),
		.q_push         (q_push),
		.q_item         (q_wr_item),
		.q_full         (q_full)
	);

	pphm_beat_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_item (q_wr_item),
		.q_full  (q_full),
		.rd      (q_pop),
		.rd_item (q_rd_item),
		.q_empty (q_empty)
	);

	pphm_back #(
		.BEAT_WINDOW (BEAT_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_item    (q_rd_item),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.res       (res),
		.res_valid (res_valid),
		.pop       (pop)
	);

	// result beat onto the ports
	assign empty          = !res_valid;
	assign smoothed       = res.smoothed;
	assign sensor_ready   = res.sensor_ready;
	assign peak_found     = res.peak_found;
	assign window_done    = res.window_done;
	assign window_error   = res.window_error;
	assign fatigue        = res.fatigue;
	assign heart_rate_bpm = res.heart_rate_bpm;
	assign mean_rr_q10    = res.mean_rr_q10;

endmodule

// ----- hw/rtl/pphm_front.sv -----
// front part: moving average, sensor ready and peak classification
module pphm_front #(
	parameter int SMOOTH_TAPS = pphm_pkg::SMOOTH_TAPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pphm_pkg::cfg_t                 cfg,
	input  logic                           push,
	output logic                           full,
	input  logic [pphm_pkg::SAMPLE_W-1:0]  sample,
	input  logic [pphm_pkg::TIME_W-1:0]    sample_time_ms,
	output logic                           q_push,
	output pphm_pkg::front_item_t          q_item,
	input  logic                           q_full
);
	import pphm_pkg::*;

	localparam int PW       = (SMOOTH_TAPS > 1) ? $clog2(SMOOTH_TAPS) : 1;
	localparam int RECIP_SH = 20;
	localparam int RECIP_W  = 21;
	localparam int PROD_W   = TOTAL_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + SMOOTH_TAPS - 1) / SMOOTH_TAPS);
	localparam logic [PW-1:0] POS_LAST = PW'(SMOOTH_TAPS - 1);

	logic [SAMPLE_W-1:0] ring_q [SMOOTH_TAPS];
	logic [TOTAL_W-1:0]  total_q;
	logic [PW-1:0]       pos_q;
	logic                valid_s1;
	logic [TIME_W-1:0]   time_s1;
	logic [SAMPLE_W-1:0] prev_smoothed_q;
	logic [TIME_W-1:0]   prev_time_q;
	logic [TIME_W-1:0]   last_peak_q;

	logic                accept;
	logic [PROD_W-1:0]   prod;
	logic [SAMPLE_W-1:0] smoothed;
	logic                ready;
	logic [TIME_W-1:0]   since_peak;
	logic                peak;

	// handshake: one item in the averaging stage at a time
	assign accept = push && !full;
	assign full   = valid_s1 && q_full;
	assign q_push = valid_s1 && !q_full;

	// running sum and ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SMOOTH_TAPS; i++) begin
				ring_q[i] <= '0;
			end
			total_q  <= '0;
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				total_q       <= total_q - TOTAL_W'(ring_q[pos_q]) + TOTAL_W'(sample);
				ring_q[pos_q] <= sample;
				pos_q         <= (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
				valid_s1      <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			time_s1 <= sample_time_ms;
		end
	end

	// average by reciprocal multiply, then peak test
	assign prod       = PROD_W'(total_q) * PROD_W'(RECIP);
	assign smoothed   = prod[RECIP_SH +: SAMPLE_W];
	assign ready      = smoothed > cfg.ready_level;
	assign since_peak = time_s1 - last_peak_q;
	assign peak       = ready && (smoothed < prev_smoothed_q) &&
		(prev_smoothed_q > cfg.peak_threshold) && (since_peak > TIME_W'(cfg.refractory_ms));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_smoothed_q <= '0;
			prev_time_q     <= '0;
			last_peak_q     <= '0;
		end else if (q_push) begin
			prev_smoothed_q <= smoothed;
			prev_time_q     <= time_s1;
			if (peak) begin
				last_peak_q <= prev_time_q;
			end
		end
	end

	assign q_item.smoothed     = smoothed;
	assign q_item.sensor_ready = ready;
	assign q_item.peak_found   = peak;
	assign q_item.beat_time    = prev_time_q;

endmodule

// ----- hw/rtl/pphm_beat_queue.sv -----
// short queue between the front and back parts
module pphm_beat_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  pphm_pkg::front_item_t wr_item,
	output logic                  q_full,
	input  logic                  rd,
	output pphm_pkg::front_item_t rd_item,
	output logic                  q_empty
);
	import pphm_pkg::*;

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QPW-1:0] PTR_LAST = QPW'(QUEUE_DEPTH - 1);

	front_item_t    slot_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_wr;
	logic           do_rd;

	assign q_full  = count_q == QCW'(QUEUE_DEPTH);
	assign q_empty = count_q == '0;
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_item = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + QPW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + QPW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ----- hw/rtl/pphm_divider.sv -----
// restoring divider, one quotient bit per cycle
module pphm_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pphm_pkg::DIV_NUM_W-1:0] num,
	input  logic [pphm_pkg::DIV_DEN_W-1:0] den,
	output logic                           busy,
	output logic                           done,
	output logic [pphm_pkg::DIV_NUM_W-1:0] quo
);
	import pphm_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- hw/rtl/pphm_back.sv -----
// back part: beat store, window statistics, rate and interval results
module pphm_back #(
	parameter int BEAT_WINDOW = pphm_pkg::BEAT_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pphm_pkg::cfg_t        cfg,
	input  pphm_pkg::front_item_t q_item,
	input  logic                  q_empty,
	output logic                  q_pop,
	output pphm_pkg::result_t     res,
	output logic                  res_valid,
	input  logic                  pop
);
	import pphm_pkg::*;

	localparam int AW  = $clog2(BEAT_WINDOW);
	localparam int CW  = $clog2(BEAT_WINDOW);
	localparam int IW  = $clog2(BEAT_WINDOW + 2);
	localparam int SW  = TIME_W + CW;
	localparam int TAW = TOL_W + CW;
	localparam int FW  = CW + 4;
	localparam logic [AW-1:0] POS_LAST = AW'(BEAT_WINDOW - 1);
	localparam logic [IW-1:0] IDX_LAST = IW'(BEAT_WINDOW);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_TOL  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_HR   = 3'd4;
	localparam logic [2:0] ST_RR   = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [TIME_W-1:0] beat_mem [BEAT_WINDOW];
	logic [TIME_W-1:0] rd_data_q;
	logic [AW-1:0]     rd_addr;

	logic [2:0]          state_q;
	logic [AW-1:0]       beat_pos_q;
	logic [IW-1:0]       idx_q;
	logic [TIME_W-1:0]   prev_q;
	logic [TIME_W-1:0]   tot_q;
	logic [CW-1:0]       acc_q;
	logic [CW-1:0]       ins_q;
	logic [TAW-1:0]      tol_acc_q;
	logic [SW-1:0]       scaled_q;
	logic                sv_q;
	logic                err_q;
	logic [SAMPLE_W-1:0] cur_smoothed_q;
	logic                cur_ready_q;
	logic                fatigue_q;
	logic [HR_W-1:0]     hr_q;
	logic [RR_W-1:0]     rr_q;
	result_t             res_q;
	logic                res_valid_q;

	logic                 slot_free;
	logic                 take;
	logic                 win_done;
	logic [TIME_W-1:0]    gap;
	logic                 gap_ok;
	logic                 pair_live;
	logic [TIME_W-1:0]    tot_d;
	logic [CW-1:0]        acc_d;
	logic [SW-1:0]        tot_ext;
	logic [SW-1:0]        diff;
	logic                 inside_hit;
	logic [CW-1:0]        ins_d;
	logic [FW-1:0]        ten_ins;
	logic [FW-1:0]        nine_acc;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_busy;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;

	assign slot_free = !res_valid_q || pop;
	assign take      = (state_q == ST_IDLE) && !q_empty && slot_free;
	assign q_pop     = take;
	assign win_done  = take && q_item.peak_found && (beat_pos_q == POS_LAST);

	// beat time memory
	assign rd_addr = (idx_q < IDX_LAST) ? idx_q[AW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (take && q_item.peak_found) begin
			beat_mem[beat_pos_q] <= q_item.beat_time;
		end
		rd_data_q <= beat_mem[rd_addr];
	end

	// gap of the pair now on the read port
	assign gap       = rd_data_q - prev_q;
	assign gap_ok    = gap < TIME_W'(cfg.reject_gap_ms);
	assign pair_live = (idx_q >= IW'(2)) && (idx_q <= IDX_LAST);
	assign tot_d     = (pair_live && gap_ok) ? tot_q + gap : tot_q;
	assign acc_d     = (pair_live && gap_ok) ? acc_q + CW'(1) : acc_q;

	// tolerance test on the registered product
	assign tot_ext    = SW'(tot_q);
	assign diff       = (scaled_q > tot_ext) ? scaled_q - tot_ext : tot_ext - scaled_q;
	assign inside_hit = sv_q && (diff < SW'(tol_acc_q));
	assign ins_d      = inside_hit ? ins_q + CW'(1) : ins_q;

	assign ten_ins  = FW'(ins_q) * FW'(10);
	assign nine_acc = FW'(acc_q) * FW'(9);

	// divider operands
	always_comb begin
		div_start = 1'b0;
		div_num   = DIV_NUM_W'(acc_q) * DIV_NUM_W'(HR_SCALE);
		div_den   = tot_q;
		if (state_q == ST_FIN) begin
			div_start = tot_q != '0;
		end else if (state_q == ST_HR) begin
			div_start = div_done;
			div_num   = {tot_q, {RR_SHIFT{1'b0}}};
			div_den   = DIV_DEN_W'(acc_q) * DIV_DEN_W'(RR_DEN_SCALE);
		end
	end

	pphm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// window sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			beat_pos_q <= '0;
			idx_q      <= '0;
			sv_q       <= 1'b0;
			err_q      <= 1'b0;
			fatigue_q  <= 1'b0;
			hr_q       <= '0;
			rr_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take && q_item.peak_found) begin
						beat_pos_q <= (beat_pos_q == POS_LAST) ? '0 : beat_pos_q + AW'(1);
					end
					if (win_done) begin
						state_q <= ST_SUM;
						idx_q   <= '0;
						err_q   <= 1'b0;
					end
				end
				ST_SUM: begin
					if (idx_q == IDX_LAST) begin
						idx_q <= '0;
						if (acc_d == '0) begin
							err_q   <= 1'b1;
							state_q <= ST_OUT;
						end else if (tot_d == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_TOL;
						end
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_TOL: begin
					if (idx_q == IDX_LAST + IW'(1)) begin
						idx_q   <= '0;
						sv_q    <= 1'b0;
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + IW'(1);
						sv_q  <= pair_live;
					end
				end
				ST_FIN: begin
					fatigue_q <= ten_ins >= nine_acc;
					if (tot_q == '0) begin
						hr_q    <= HR_W'(HR_MAX);
						rr_q    <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_HR;
					end
				end
				ST_HR: begin
					if (div_done) begin
						hr_q    <= (div_quo > DIV_NUM_W'(HR_MAX)) ? HR_W'(HR_MAX) : div_quo[HR_W-1:0];
						state_q <= ST_RR;
					end
				end
				ST_RR: begin
					if (div_done) begin
						rr_q    <= (div_quo > DIV_NUM_W'(RR_MAX)) ? RR_W'(RR_MAX) : div_quo[RR_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// window accumulators
	always_ff @(posedge clk) begin
		if (win_done) begin
			cur_smoothed_q <= q_item.smoothed;
			cur_ready_q    <= q_item.sensor_ready;
			tot_q          <= '0;
			acc_q          <= '0;
			ins_q          <= '0;
		end
		if (state_q == ST_SUM) begin
			prev_q <= rd_data_q;
			tot_q  <= tot_d;
			acc_q  <= acc_d;
			if (idx_q == IDX_LAST) begin
				tol_acc_q <= TAW'(cfg.tolerance_ms) * TAW'(acc_d);
			end
		end
		if (state_q == ST_TOL) begin
			prev_q   <= rd_data_q;
			scaled_q <= SW'(gap) * SW'(acc_q);
			ins_q    <= ins_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((take && !win_done) || (state_q == ST_OUT && slot_free)) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !win_done) begin
			res_q.smoothed       <= q_item.smoothed;
			res_q.sensor_ready   <= q_item.sensor_ready;
			res_q.peak_found     <= q_item.peak_found;
			res_q.window_done    <= 1'b0;
			res_q.window_error   <= 1'b0;
			res_q.fatigue        <= fatigue_q;
			res_q.heart_rate_bpm <= hr_q;
			res_q.mean_rr_q10    <= rr_q;
		end else if (state_q == ST_OUT && slot_free) begin
			res_q.smoothed       <= cur_smoothed_q;
			res_q.sensor_ready   <= cur_ready_q;
			res_q.peak_found     <= 1'b1;
			res_q.window_done    <= 1'b1;
			res_q.window_error   <= err_q;
			res_q.fatigue        <= fatigue_q;
			res_q.heart_rate_bpm <= hr_q;
			res_q.mean_rr_q10    <= rr_q;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

`ifndef SYNTHESIS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider started while busy");
	a_win_enter: assert property (@(posedge clk) disable iff (!arst_n)
		win_done |=> state_q == ST_SUM) else $error("window evaluation not started");
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.window_error) |-> res_q.window_done)
		else $error("window error without window done");
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (beat_pos_q == '0 && !q_pop))
		else $error("beat taken during window evaluation");
`endif

endmodule
